FILE: hdl/lcsf_pkg.sv
// Shared types, constants and the base encoder for the complementary stem finder.
// No dependencies; imported by the base store, the pair checker and the top level.
package lcsf_pkg;

   // 3-bit nucleotide codes held in the base store
   typedef logic [2:0] code_type;

   localparam code_type CODE_OTHER = 3'd0;
   localparam code_type CODE_A     = 3'd1;
   localparam code_type CODE_C     = 3'd2;
   localparam code_type CODE_G     = 3'd3;
   localparam code_type CODE_T     = 3'd4;

   // ASCII characters of interest
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_C     = 8'h43;
   localparam logic [7:0] CHAR_G     = 8'h47;
   localparam logic [7:0] CHAR_T     = 8'h54;
   localparam logic [7:0] CHAR_U     = 8'h55;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z = 8'h7a;
   localparam logic [7:0] CASE_DELTA = 8'h20;

   // Case-fold a character and map it to its code, U read as T
   function automatic code_type encode_base(input logic [7:0] ch);
      logic [7:0] up;
      code_type   code;
      up = ch;
      if (ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z) begin
         up = ch - CASE_DELTA;
      end
      unique case (up)
         CHAR_A:  code = CODE_A;
         CHAR_C:  code = CODE_C;
         CHAR_G:  code = CODE_G;
         CHAR_T:  code = CODE_T;
         CHAR_U:  code = CODE_T;
         default: code = CODE_OTHER;
      endcase
      return code;
   endfunction

endpackage

FILE: hdl/lcsf_base_store.sv
// Window store of base codes: one write port, two registered read ports.
// Depends on lcsf_pkg for the code type.
module lcsf_base_store
   import lcsf_pkg::*;
#(
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  code_type      wr_code,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   output code_type      rd_code_a,
   output code_type      rd_code_b
);

   code_type mem [DEPTH];
   code_type rd_code_a_ff;
   code_type rd_code_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_code;
      end
   end

   // two read ports, data registered
   always_ff @(posedge clock) begin
      rd_code_a_ff <= mem[rd_addr_a];
      rd_code_b_ff <= mem[rd_addr_b];
   end

   assign rd_code_a = rd_code_a_ff;
   assign rd_code_b = rd_code_b_ff;

endmodule

FILE: hdl/lcsf_pair_check.sv
// Base-pair compare unit shared by every extension step of the search.
// Depends on lcsf_pkg for the code constants.
module lcsf_pair_check
   import lcsf_pkg::*;
(
   input  code_type code_a,
   input  code_type code_b,
   input  logic     wobble_enable,
   output logic     is_pair
);

   logic cg_pair;
   logic at_pair;
   logic gt_pair;

   // Watson-Crick pairs, plus G-T wobble when enabled
   always_comb begin
      cg_pair = (code_a == CODE_C && code_b == CODE_G) ||
                (code_a == CODE_G && code_b == CODE_C);
      at_pair = (code_a == CODE_A && code_b == CODE_T) ||
                (code_a == CODE_T && code_b == CODE_A);
      gt_pair = (code_a == CODE_G && code_b == CODE_T) ||
                (code_a == CODE_T && code_b == CODE_G);
      is_pair = cg_pair || at_pair || (wobble_enable && gt_pair);
   end

endmodule

FILE: hdl/longest_complementary_stem_finder.sv
// Longest complementary stem finder. Bases of one window are taken one per cycle
// (req_stall low while loading) and written to a WINDOW_MAX-entry store; bases past
// WINDOW_MAX are dropped and flagged. The request with req_is_last set starts the
// search, during which req_stall stays high. The search visits every position pair
// i <= j of the stored window and extends the stem outward one base at a time through
// a single pair-compare unit fed by the two read ports of the store. Each pair passes
// through an address step, a compare step and a close step, with a further address
// and compare step for each paired base; the compare step is skipped when the stem
// runs into an end of the window. The result is held in an output register, and
// loading of the next window may start while it waits; a search that finishes while
// the previous result is still stalled waits for it. The wobble register is written
// through the csr port, which is always ready.
module longest_complementary_stem_finder
   import lcsf_pkg::*;
#(
   parameter int WINDOW_MAX = 256
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_base_char,
   input  logic              req_is_last,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_stem_length,
   output logic [7:0]        rsp_left_arm_start,
   output logic [7:0]        rsp_left_arm_end,
   output logic [7:0]        rsp_right_arm_start,
   output logic signed [8:0] rsp_right_arm_end,
   output logic              rsp_overflow_flag,
   // configuration
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_wobble_enable
);

   localparam int AW = $clog2(WINDOW_MAX);
   localparam int CW = $clog2(WINDOW_MAX + 1);

   typedef enum logic [1:0] {
      S_LOAD,
      S_PAIR,
      S_CMP,
      S_FIN
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic              wobble_ff, wobble_in;
   logic [AW-1:0]     i_ff, i_in;
   logic [AW-1:0]     j_ff, j_in;
   logic [CW-1:0]     len_ff, len_in;
   logic [CW-1:0]     best_ff, best_in;
   logic [AW-1:0]     bi_ff, bi_in;
   logic [AW-1:0]     bj_ff, bj_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        stem_ff, stem_in;
   logic [7:0]        ls_ff, ls_in;
   logic [7:0]        le_ff, le_in;
   logic [7:0]        rs_ff, rs_in;
   logic [8:0]        re_ff, re_in;
   logic              rovf_ff, rovf_in;

   logic              accept;
   logic              wr_en;
   logic [AW-1:0]     rd_addr_a;
   logic [AW-1:0]     rd_addr_b;
   code_type          rd_code_a;
   code_type          rd_code_b;
   code_type          wr_code;
   logic              is_pair;
   logic              ext_ok;
   logic              upd_best;
   logic [CW-1:0]     fin_best;
   logic [AW-1:0]     fin_bi;
   logic [AW-1:0]     fin_bj;
   logic              last_j;
   logic              last_i;
   logic              rsp_free;
   logic [31:0]       best_w;
   logic [31:0]       bi_w;
   logic [31:0]       bj_w;
   logic [31:0]       ls_w;
   logic [31:0]       re_w;

   lcsf_base_store #(
      .DEPTH (WINDOW_MAX)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (count_ff[AW-1:0]),
      .wr_code   (wr_code),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_code_a (rd_code_a),
      .rd_code_b (rd_code_b)
   );

   lcsf_pair_check u_pair (
      .code_a        (rd_code_a),
      .code_b        (rd_code_b),
      .wobble_enable (wobble_ff),
      .is_pair       (is_pair)
   );

   assign req_stall = (state_ff != S_LOAD);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign wr_code   = encode_base(req_base_char);
   assign wr_en     = accept && (count_ff < CW'(WINDOW_MAX));

   // addresses of the next outward step: left at i-len, right at j+len
   assign rd_addr_a = AW'(CW'(i_ff) - len_ff);
   assign rd_addr_b = AW'(CW'(j_ff) + len_ff);
   assign ext_ok    = (len_ff <= CW'(i_ff)) &&
                      ((CW + 1)'(j_ff) + (CW + 1)'(len_ff) < (CW + 1)'(count_ff));

   // best so far including the pair just finished
   assign upd_best = (len_ff > best_ff);
   assign fin_best = upd_best ? len_ff : best_ff;
   assign fin_bi   = upd_best ? i_ff : bi_ff;
   assign fin_bj   = upd_best ? j_ff : bj_ff;
   assign last_j   = (CW'(j_ff) + CW'(1) == count_ff);
   assign last_i   = (CW'(i_ff) + CW'(1) == count_ff);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // result field arithmetic, masked to the field widths
   assign best_w = 32'(fin_best);
   assign bi_w   = 32'(fin_bi);
   assign bj_w   = 32'(fin_bj);
   assign ls_w   = bi_w + 32'd1 - best_w;
   assign re_w   = bj_w + best_w - 32'd1;

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      wobble_in    = wobble_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      len_in       = len_ff;
      best_in      = best_ff;
      bi_in        = bi_ff;
      bj_in        = bj_ff;
      rsp_valid_in = rsp_valid_ff;
      stem_in      = stem_ff;
      ls_in        = ls_ff;
      le_in        = le_ff;
      rs_in        = rs_ff;
      re_in        = re_ff;
      rovf_in      = rovf_ff;

      if (csr_valid && csr_ready) begin
         wobble_in = csr_wobble_enable;
      end

      // result taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (wr_en) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_is_last) begin
                  i_in     = '0;
                  j_in     = '0;
                  len_in   = '0;
                  best_in  = '0;
                  bi_in    = '0;
                  bj_in    = '0;
                  state_in = S_PAIR;
               end
            end
         end
         S_PAIR: begin
            state_in = ext_ok ? S_CMP : S_FIN;
         end
         S_CMP: begin
            if (is_pair) begin
               len_in   = len_ff + CW'(1);
               state_in = S_PAIR;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            best_in = fin_best;
            bi_in   = fin_bi;
            bj_in   = fin_bj;
            if (!last_j) begin
               j_in     = j_ff + AW'(1);
               len_in   = '0;
               state_in = S_PAIR;
            end else if (!last_i) begin
               i_in     = i_ff + AW'(1);
               j_in     = i_ff + AW'(1);
               len_in   = '0;
               state_in = S_PAIR;
            end else if (rsp_free) begin
               // search done: publish and open the next window
               rsp_valid_in = 1'b1;
               stem_in      = best_w[7:0];
               ls_in        = ls_w[7:0];
               le_in        = bi_w[7:0];
               rs_in        = bj_w[7:0];
               re_in        = re_w[8:0];
               rovf_in      = ovf_ff;
               count_in     = '0;
               ovf_in       = 1'b0;
               state_in     = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         wobble_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         wobble_ff    <= wobble_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff    <= i_in;
      j_ff    <= j_in;
      len_ff  <= len_in;
      best_ff <= best_in;
      bi_ff   <= bi_in;
      bj_ff   <= bj_in;
      stem_ff <= stem_in;
      ls_ff   <= ls_in;
      le_ff   <= le_in;
      rs_ff   <= rs_in;
      re_ff   <= re_in;
      rovf_ff <= rovf_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_stem_length     = stem_ff;
   assign rsp_left_arm_start  = ls_ff;
   assign rsp_left_arm_end    = le_ff;
   assign rsp_right_arm_start = rs_ff;
   assign rsp_right_arm_end   = $signed(re_ff);
   assign rsp_overflow_flag   = rovf_ff;

endmodule
